### rtl/idq_pkg.sv
// idq_pkg: shared types and codes for the indexed deque
// command and result transfer structs, command codes, status codes
// no dependencies
`default_nettype none

package idq_pkg;

    // command codes
    localparam logic [3:0] CMD_PUSH_BACK  = 4'd0;
    localparam logic [3:0] CMD_PUSH_FRONT = 4'd1;
    localparam logic [3:0] CMD_PUSH_AT    = 4'd2;
    localparam logic [3:0] CMD_GET_BACK   = 4'd3;
    localparam logic [3:0] CMD_GET_FRONT  = 4'd4;
    localparam logic [3:0] CMD_GET_AT     = 4'd5;
    localparam logic [3:0] CMD_POP_BACK   = 4'd6;
    localparam logic [3:0] CMD_POP_FRONT  = 4'd7;
    localparam logic [3:0] CMD_POP_AT     = 4'd8;
    localparam logic [3:0] CMD_COUNT      = 4'd9;
    localparam logic [3:0] CMD_FLUSH      = 4'd10;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // one command transfer
    typedef struct packed {
        logic [3:0]  command;
        logic [6:0]  position;
        logic [31:0] item_in;
    } t_cmd_in;

    // one result transfer
    typedef struct packed {
        logic [31:0] item_out;
        logic [6:0]  count_out;
        logic [1:0]  status;
    } t_result;

endpackage

`default_nettype wire

### rtl/idq_ram.sv
// idq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/indexed_deque.sv
// indexed_deque: bounded ordered list with push, get and pop at back, front or index
// depends on idq_pkg and idq_ram
// sequence: count, flush, spare codes, errors and push at the back go from idle straight to the finish step;
//   other commands walk through run (one ram read per cycle), drain and finish, and for push
//   and pop the entries shift by one place through the single read and write port
// throughput: one command at a time, busy is high until the result cycle
// reset: synchronous active low, clears the count and control; ram contents are not cleared
`default_nettype none

module indexed_deque #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire idq_pkg::t_cmd_in i_cmd,
    output logic                  o_done,
    output idq_pkg::t_result      o_result
);

    localparam int SW = (ITEM_WIDTH < 32) ? ITEM_WIDTH : 32;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        K_NONE,
        K_PUSH,
        K_GET,
        K_POP,
        K_FLUSH
    } t_kind;

    t_state           r_state, n_state;
    t_kind            r_kind, n_kind;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_at, n_at;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_end, n_end;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_paddr, n_paddr;
    logic [SW-1:0]    r_item, n_item;
    logic [SW-1:0]    r_res, n_res;
    logic [1:0]       r_status, n_status;
    logic             r_done, n_done;
    idq_pkg::t_result r_out, n_out;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [SW-1:0]    ram_wdata;
    logic [SW-1:0]    ram_rdata;

    // command decode
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    pos_x;
    logic [XW-1:0]    at_x;
    logic             is_push;
    logic             is_read;
    logic             is_pop;
    logic             full;
    logic             bad;

    assign cnt_x = XW'(r_count);
    assign pos_x = XW'(i_cmd.position);
    assign full  = (r_count == CW'(CAPACITY));

    always_comb begin
        is_push = 1'b0;
        is_read = 1'b0;
        is_pop  = 1'b0;
        at_x    = '0;
        case (i_cmd.command)
            idq_pkg::CMD_PUSH_BACK: begin
                is_push = 1'b1;
                at_x    = cnt_x;
            end
            idq_pkg::CMD_PUSH_FRONT: begin
                is_push = 1'b1;
            end
            idq_pkg::CMD_PUSH_AT: begin
                is_push = 1'b1;
                at_x    = pos_x;
            end
            idq_pkg::CMD_GET_BACK: begin
                is_read = 1'b1;
                at_x    = XW'(cnt_x - XW'(1));
            end
            idq_pkg::CMD_GET_FRONT: begin
                is_read = 1'b1;
            end
            idq_pkg::CMD_GET_AT: begin
                is_read = 1'b1;
                at_x    = pos_x;
            end
            idq_pkg::CMD_POP_BACK: begin
                is_pop = 1'b1;
                at_x   = XW'(cnt_x - XW'(1));
            end
            idq_pkg::CMD_POP_FRONT: begin
                is_pop = 1'b1;
            end
            idq_pkg::CMD_POP_AT: begin
                is_pop = 1'b1;
                at_x   = pos_x;
            end
            default: begin
            end
        endcase
        if (is_push) begin
            bad = full || (at_x > cnt_x);
        end else begin
            bad = (r_count == '0) || (at_x >= cnt_x);
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_count   = r_count;
        n_at      = r_at;
        n_ptr     = r_ptr;
        n_end     = r_end;
        n_pend    = 1'b0;
        n_paddr   = r_ptr;
        n_item    = r_item;
        n_res     = r_res;
        n_status  = r_status;
        n_done    = 1'b0;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_at;
        ram_wdata = r_item;

        // pending read data: shift one place or capture the addressed entry
        if (r_pend) begin
            if (r_kind == K_PUSH) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_paddr + AW'(1));
                ram_wdata = ram_rdata;
            end else if (r_kind == K_POP && r_paddr != r_at) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_paddr - AW'(1));
                ram_wdata = ram_rdata;
            end
            if ((r_kind == K_GET || r_kind == K_POP) && r_paddr == r_at) begin
                n_res = ram_rdata;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item   = i_cmd.item_in[SW-1:0];
                    n_res    = '0;
                    n_status = idq_pkg::STAT_OK;
                    n_kind   = K_NONE;
                    n_at     = at_x[AW-1:0];
                    n_state  = ST_FIN;
                    if (is_push || is_read || is_pop) begin
                        if (bad) begin
                            n_status = (is_push && full) ? idq_pkg::STAT_FULL
                                                         : idq_pkg::STAT_RANGE;
                        end else if (is_push) begin
                            n_kind = K_PUSH;
                            n_res  = i_cmd.item_in[SW-1:0];
                            n_ptr  = AW'(r_count - CW'(1));
                            n_end  = at_x[AW-1:0];
                            if (at_x != cnt_x) begin
                                n_state = ST_RUN;
                            end
                        end else if (is_read) begin
                            n_kind  = K_GET;
                            n_ptr   = at_x[AW-1:0];
                            n_end   = at_x[AW-1:0];
                            n_state = ST_RUN;
                        end else begin
                            n_kind  = K_POP;
                            n_ptr   = at_x[AW-1:0];
                            n_end   = AW'(r_count - CW'(1));
                            n_state = ST_RUN;
                        end
                    end else if (i_cmd.command == idq_pkg::CMD_FLUSH) begin
                        n_kind = K_FLUSH;
                    end
                end
            end
            ST_RUN: begin
                // one read per cycle, walking toward the end address
                n_pend  = 1'b1;
                n_paddr = r_ptr;
                if (r_ptr == r_end) begin
                    n_state = ST_DRAIN;
                end else if (r_kind == K_PUSH) begin
                    n_ptr = AW'(r_ptr - AW'(1));
                end else begin
                    n_ptr = AW'(r_ptr + AW'(1));
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                case (r_kind)
                    K_PUSH: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_at;
                        ram_wdata = r_item;
                        n_count   = CW'(r_count + CW'(1));
                    end
                    K_POP: begin
                        n_count = CW'(r_count - CW'(1));
                    end
                    K_FLUSH: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
                n_done          = 1'b1;
                n_out.item_out  = 32'(r_res);
                n_out.count_out = 7'(n_count);
                n_out.status    = r_status;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= K_NONE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_at     <= n_at;
        r_ptr    <= n_ptr;
        r_end    <= n_end;
        r_paddr  <= n_paddr;
        r_item   <= n_item;
        r_res    <= n_res;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // entry storage
    idq_ram #(
        .WIDTH(SW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_ptr),
        .o_rdata(ram_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    // a result transfer only follows the finish step
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_FIN))
        else $error("result strobe without finish step");

    // the count changes only at the finish step
    a_count_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> $past(r_state == ST_FIN))
        else $error("count changed outside finish step");

    // no read is outstanding while idle
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("read outstanding while idle");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for indexed_deque, directed table then random command mix
// keeps a copy of the list and checks results against it, pinned rows against the table
// depends on idq_pkg and the indexed_deque rtl

module testbench;

    localparam int          DEPTH           = 64;
    localparam int          RANDOM_CMDS     = 1450;
    localparam int          STALL_LIMIT     = 4000;
    localparam int          IDLE_PCT        = 11;
    localparam int          DIR_ROWS        = 20;
    localparam logic [3:0]  CMD_SPARE_FIRST = 4'd11;
    localparam logic [3:0]  CMD_SPARE_LAST  = 4'd15;
    localparam logic [31:0] ALL_ONES        = 32'hffff_ffff;
    localparam logic [6:0]  POS_MAX         = 7'd127;

    // random segment flavors
    typedef enum logic [1:0] {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN
    } t_mix;

    // one row of the directed table
    typedef struct {
        idq_pkg::t_cmd_in cmd;
        bit               pinned;
        idq_pkg::t_result want;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    idq_pkg::t_cmd_in i_cmd;
    logic             o_done;
    idq_pkg::t_result o_result;

    bit [31:0]        held_items[$];
    idq_pkg::t_result pending_results[$];
    idq_pkg::t_cmd_in pending_cmds[$];
    int               mismatch_count;
    int               stall_cycles;
    bit               idle_enabled;
    t_dir_row         dir_rows[DIR_ROWS];

    indexed_deque #(
        .CAPACITY(DEPTH),
        .ITEM_WIDTH(32)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .o_done(o_done),
        .o_result(o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // list behavior: applies one command to the local copy, returns its result
    function automatic idq_pkg::t_result apply_deque_cmd(idq_pkg::t_cmd_in c);
        idq_pkg::t_result r;
        int               n;
        int               at;
        r  = '0;
        n  = held_items.size();
        at = 0;
        case (c.command)
            idq_pkg::CMD_PUSH_BACK, idq_pkg::CMD_PUSH_FRONT, idq_pkg::CMD_PUSH_AT: begin
                if (c.command == idq_pkg::CMD_PUSH_BACK) at = n;
                else if (c.command == idq_pkg::CMD_PUSH_FRONT) at = 0;
                else at = c.position;
                if (n >= DEPTH) begin
                    r.status = idq_pkg::STAT_FULL;
                end else if (at > n) begin
                    r.status = idq_pkg::STAT_RANGE;
                end else begin
                    held_items.insert(at, c.item_in);
                    r.item_out = c.item_in;
                end
            end
            idq_pkg::CMD_GET_BACK, idq_pkg::CMD_GET_FRONT, idq_pkg::CMD_GET_AT,
            idq_pkg::CMD_POP_BACK, idq_pkg::CMD_POP_FRONT, idq_pkg::CMD_POP_AT: begin
                if (c.command == idq_pkg::CMD_GET_BACK || c.command == idq_pkg::CMD_POP_BACK)
                    at = n - 1;
                else if (c.command == idq_pkg::CMD_GET_FRONT ||
                         c.command == idq_pkg::CMD_POP_FRONT)
                    at = 0;
                else at = c.position;
                if (n == 0 || at >= n) begin
                    r.status = idq_pkg::STAT_RANGE;
                end else begin
                    r.item_out = held_items[at];
                    if (c.command == idq_pkg::CMD_POP_BACK ||
                        c.command == idq_pkg::CMD_POP_FRONT ||
                        c.command == idq_pkg::CMD_POP_AT) begin
                        held_items.delete(at);
                    end
                end
            end
            idq_pkg::CMD_FLUSH: begin
                held_items.delete();
            end
            default: begin
            end
        endcase
        r.count_out = 7'(held_items.size());
        return r;
    endfunction

    function automatic t_dir_row dir_row(logic [3:0] cmd, logic [6:0] pos, logic [31:0] item,
                                         bit pinned, logic [31:0] want_item,
                                         logic [6:0] want_count, logic [1:0] want_status);
        t_dir_row d;
        d.cmd.command      = cmd;
        d.cmd.position     = pos;
        d.cmd.item_in      = item;
        d.pinned           = pinned;
        d.want.item_out    = want_item;
        d.want.count_out   = want_count;
        d.want.status      = want_status;
        return d;
    endfunction

    // drive one command and hold it until the transfer, then queue its expected result
    task automatic issue_cmd(idq_pkg::t_cmd_in c, bit pinned, idq_pkg::t_result want);
        idq_pkg::t_result predicted;
        while (idle_enabled && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        predicted = apply_deque_cmd(c);
        pending_results.push_back(pinned ? want : predicted);
        pending_cmds.push_back(c);
    endtask

    function automatic logic [6:0] pick_position(int n);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 7'($urandom_range(n > 0 ? n - 1 : 0));
            5:             return 7'(n);
            6:             return 7'(n + 1);
            7:             return POS_MAX;
            default:       return 7'($urandom_range(127));
        endcase
    endfunction

    function automatic logic [31:0] pick_item();
        case ($urandom_range(19))
            0:       return '0;
            1:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_push();
        case ($urandom_range(2))
            0:       return idq_pkg::CMD_PUSH_BACK;
            1:       return idq_pkg::CMD_PUSH_FRONT;
            default: return idq_pkg::CMD_PUSH_AT;
        endcase
    endfunction

    function automatic logic [3:0] pick_read();
        case ($urandom_range(2))
            0:       return idq_pkg::CMD_GET_BACK;
            1:       return idq_pkg::CMD_GET_FRONT;
            default: return idq_pkg::CMD_GET_AT;
        endcase
    endfunction

    function automatic logic [3:0] pick_pop();
        case ($urandom_range(2))
            0:       return idq_pkg::CMD_POP_BACK;
            1:       return idq_pkg::CMD_POP_FRONT;
            default: return idq_pkg::CMD_POP_AT;
        endcase
    endfunction

    // command choice weighted by segment flavor
    function automatic idq_pkg::t_cmd_in random_cmd(t_mix mix);
        idq_pkg::t_cmd_in c;
        int               r;
        r          = $urandom_range(99);
        c.position = pick_position(held_items.size());
        c.item_in  = pick_item();
        case (mix)
            MIX_FILL: begin
                if (r < 80) c.command = pick_push();
                else if (r < 90) c.command = pick_read();
                else if (r < 97) c.command = pick_pop();
                else c.command = idq_pkg::CMD_COUNT;
            end
            MIX_DRAIN: begin
                if (r < 65) c.command = pick_pop();
                else if (r < 82) c.command = pick_read();
                else if (r < 95) c.command = pick_push();
                else c.command = idq_pkg::CMD_COUNT;
            end
            default: begin
                if (r < 40) c.command = pick_push();
                else if (r < 65) c.command = pick_read();
                else if (r < 88) c.command = pick_pop();
                else if (r < 93) c.command = idq_pkg::CMD_COUNT;
                else if (r < 95) c.command = idq_pkg::CMD_FLUSH;
                else c.command = 4'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end
        endcase
        return c;
    endfunction

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        idq_pkg::t_result want;
        idq_pkg::t_cmd_in c;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result transfer: item %h count %0d status %0d",
                             o_result.item_out, o_result.count_out, o_result.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                c    = pending_cmds.pop_front();
                if (o_result.item_out !== want.item_out ||
                    o_result.count_out !== want.count_out ||
                    o_result.status !== want.status) begin
                    if (mismatch_count < 10)
                        $display({"mismatch cmd %0d pos %0d item %h: expected item %h ",
                                  "count %0d status %0d, got item %h count %0d status %0d"},
                                 c.command, c.position, c.item_in,
                                 want.item_out, want.count_out, want.status,
                                 o_result.item_out, o_result.count_out, o_result.status);
                    mismatch_count++;
                end
            end
        end
    end

    // cycles with no transfer in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        stall_cycles = 0;
        wait (stall_cycles >= STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // reset, directed table, random segments, drain
    initial begin
        t_mix             mix;
        int               seg_left;
        idq_pkg::t_cmd_in c;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = '0;
        mismatch_count = 0;
        idle_enabled   = 1'b1;

        dir_rows = '{
            dir_row(idq_pkg::CMD_POP_BACK,   7'd0,    32'h0,         1,
                    32'h0,         7'd0, idq_pkg::STAT_RANGE),
            dir_row(idq_pkg::CMD_GET_FRONT,  7'd0,    32'h0,         1,
                    32'h0,         7'd0, idq_pkg::STAT_RANGE),
            dir_row(idq_pkg::CMD_POP_AT,     7'd0,    ALL_ONES,      1,
                    32'h0,         7'd0, idq_pkg::STAT_RANGE),
            dir_row(idq_pkg::CMD_COUNT,      POS_MAX, ALL_ONES,      1,
                    32'h0,         7'd0, idq_pkg::STAT_OK),
            dir_row(CMD_SPARE_LAST,          POS_MAX, ALL_ONES,      1,
                    32'h0,         7'd0, idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_PUSH_AT,    7'd1,    32'h1234_5678, 1,
                    32'h0,         7'd0, idq_pkg::STAT_RANGE),
            dir_row(idq_pkg::CMD_PUSH_BACK,  POS_MAX, ALL_ONES,      1,
                    ALL_ONES,      7'd1, idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_PUSH_FRONT, POS_MAX, 32'h0,         1,
                    32'h0,         7'd2, idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_PUSH_AT,    7'd2,    32'ha5a5_a5a5, 1,
                    32'ha5a5_a5a5, 7'd3, idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_PUSH_AT,    7'd1,    32'h5a5a_5a5a, 1,
                    32'h5a5a_5a5a, 7'd4, idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_GET_AT,     7'd1,    32'h0,         0,
                    '0,            '0,   idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_GET_BACK,   7'd0,    32'h0,         0,
                    '0,            '0,   idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_GET_AT,     7'd4,    32'h0,         1,
                    32'h0,         7'd4, idq_pkg::STAT_RANGE),
            dir_row(idq_pkg::CMD_GET_AT,     POS_MAX, 32'h0,         1,
                    32'h0,         7'd4, idq_pkg::STAT_RANGE),
            dir_row(idq_pkg::CMD_POP_AT,     7'd1,    32'h0,         0,
                    '0,            '0,   idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_POP_FRONT,  7'd0,    32'h0,         0,
                    '0,            '0,   idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_POP_BACK,   7'd0,    32'h0,         0,
                    '0,            '0,   idq_pkg::STAT_OK),
            dir_row(CMD_SPARE_FIRST,         7'd3,    32'h0000_0001, 0,
                    '0,            '0,   idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_FLUSH,      POS_MAX, ALL_ONES,      1,
                    32'h0,         7'd0, idq_pkg::STAT_OK),
            dir_row(idq_pkg::CMD_GET_BACK,   7'd0,    32'h0,         1,
                    32'h0,         7'd0, idq_pkg::STAT_RANGE)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[i])
            issue_cmd(dir_rows[i].cmd, dir_rows[i].pinned, dir_rows[i].want);

        // random segments of one flavor each, with a long stretch of back-to-back commands
        mix      = MIX_FILL;
        seg_left = 100;
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            if (seg_left == 0) begin
                mix      = t_mix'($urandom_range(2));
                seg_left = $urandom_range(40, 120);
            end
            seg_left--;
            idle_enabled = !(k >= 500 && k < 800);
            c = random_cmd(mix);
            issue_cmd(c, 1'b0, '0);
        end
        start <= 1'b0;

        // drain and let any stray transfer show up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### indexed_deque.f
rtl/idq_pkg.sv
rtl/idq_ram.sv
rtl/indexed_deque.sv
tb/testbench.sv
